// ----- sv/obbsat_pkg.sv -----
package obbsat_pkg;

    // field widths
    localparam int COORD_WIDTH = 32;
    localparam int AXIS_WIDTH  = 16;
    localparam int AXIS_FRAC   = AXIS_WIDTH - 2;
    localparam int HALF_W      = COORD_WIDTH - 1;

    // stream payload widths
    localparam int IN_BITS     = 2 * COORD_WIDTH + 2 * HALF_W + 4 * AXIS_WIDTH;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    // arithmetic widths along the lane
    localparam int PROD_W  = 2 * AXIS_WIDTH;          // axis by axis product
    localparam int DOT_W   = PROD_W + 1;              // sum of two products
    localparam int MAG_W   = PROD_W;                  // magnitude of a dot product
    localparam int DIFF_W  = COORD_WIDTH + 1;         // centre difference
    localparam int CPROD_W = DIFF_W + AXIS_WIDTH;     // difference by axis
    localparam int CSUM_W  = CPROD_W + 1;             // projected centre distance
    localparam int CABS_W  = CPROD_W;                 // its magnitude
    localparam int CSH_W   = CABS_W + AXIS_FRAC;      // at the radius scale
    localparam int HPROD_W = HALF_W + MAG_W;          // half extent by dot
    localparam int PSUM_W  = HPROD_W + 1;             // radius of one box
    localparam int TOT_W   = HPROD_W + 2;             // sum of both radii
    localparam int CMP_W   = (TOT_W > CSH_W) ? TOT_W : CSH_W;

    // stages that carry a valid bit ahead of the output register
    localparam int NSTAGE = 6;
    localparam int NAXES  = 4;

    // request kinds carried on tuser
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_type_t;

    typedef struct packed {
        logic signed [AXIS_WIDTH-1:0] a2y;
        logic signed [AXIS_WIDTH-1:0] a2x;
        logic signed [AXIS_WIDTH-1:0] a1y;
        logic signed [AXIS_WIDTH-1:0] a1x;
    } axes_t;

    typedef struct packed {
        axes_t                         axes;
        logic        [HALF_W-1:0]      half_y;
        logic        [HALF_W-1:0]      half_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [COORD_WIDTH-1:0] center_x;
    } box_t;

endpackage

// ----- sv/obbsat_ref_store.sv -----
module obbsat_ref_store
    import obbsat_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic load_en,
    input  box_t box_in,
    output box_t ref_box
);

    box_t ref_reg;
    box_t ref_next;

    // take a new reference box on a load request
    always_comb begin
        ref_next = ref_reg;
        if (load_en) begin
            ref_next = box_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_reg <= '0;
        end else begin
            ref_reg <= ref_next;
        end
    end

    assign ref_box = ref_reg;

endmodule

// ----- sv/obbsat_axis_lane.sv -----
module obbsat_axis_lane
    import obbsat_pkg::*;
(
    input  logic                          aclk,
    input  logic                          en,
    // stage 0: candidate axis and the four box axes
    input  logic signed [AXIS_WIDTH-1:0]  nx,
    input  logic signed [AXIS_WIDTH-1:0]  ny,
    input  axes_t                         ref_axes,
    input  axes_t                         tst_axes,
    // stage 1: centre difference
    input  logic signed [DIFF_W-1:0]      dx,
    input  logic signed [DIFF_W-1:0]      dy,
    // stage 2: half extents, reference x, y then test x, y
    input  logic [NAXES-1:0][HALF_W-1:0]  half,
    // stage 6: this axis separates the boxes
    output logic                          sep
);

    logic signed [AXIS_WIDTH-1:0] ax [NAXES];
    logic signed [AXIS_WIDTH-1:0] ay [NAXES];

    logic signed [PROD_W-1:0]  px_reg   [NAXES];
    logic signed [PROD_W-1:0]  py_reg   [NAXES];
    logic signed [AXIS_WIDTH-1:0] nx1_reg, ny1_reg;
    logic signed [DOT_W-1:0]   dot      [NAXES];
    logic        [MAG_W-1:0]   mag_reg  [NAXES];
    logic        [MAG_W-1:0]   mag_next [NAXES];
    logic signed [CPROD_W-1:0] cpx_reg, cpy_reg;
    logic        [HPROD_W-1:0] hp_reg   [NAXES];
    logic signed [CSUM_W-1:0]  csum_reg, csum_next;
    logic        [PSUM_W-1:0]  pa_reg, pb_reg;
    logic        [CABS_W-1:0]  cabs_reg, cabs_next;
    logic        [TOT_W-1:0]   tot_reg;
    logic        [CSH_W-1:0]   csh_reg;
    logic                      sep_reg;

    // box axes in fixed order: reference first, reference second, test first, test second
    always_comb begin
        ax[0] = ref_axes.a1x;  ay[0] = ref_axes.a1y;
        ax[1] = ref_axes.a2x;  ay[1] = ref_axes.a2y;
        ax[2] = tst_axes.a1x;  ay[2] = tst_axes.a1y;
        ax[3] = tst_axes.a2x;  ay[3] = tst_axes.a2y;
    end

    // stage 1: component products of the candidate axis with each box axis
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NAXES; i++) begin
                px_reg[i] <= PROD_W'(nx) * PROD_W'(ax[i]);
                py_reg[i] <= PROD_W'(ny) * PROD_W'(ay[i]);
            end
            nx1_reg <= nx;
            ny1_reg <= ny;
        end
    end

    // stage 2: absolute dot products, centre difference times axis
    always_comb begin
        for (int i = 0; i < NAXES; i++) begin
            dot[i]      = DOT_W'(px_reg[i]) + DOT_W'(py_reg[i]);
            mag_next[i] = dot[i][DOT_W-1] ? MAG_W'(-dot[i]) : MAG_W'(dot[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
            cpx_reg <= CPROD_W'(dx) * CPROD_W'(nx1_reg);
            cpy_reg <= CPROD_W'(dy) * CPROD_W'(ny1_reg);
        end
    end

    // stage 3: half extent times projected axis, projected centre distance
    assign csum_next = CSUM_W'(cpx_reg) + CSUM_W'(cpy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NAXES; i++) begin
                hp_reg[i] <= HPROD_W'(half[i]) * HPROD_W'(mag_reg[i]);
            end
            csum_reg <= csum_next;
        end
    end

    // stage 4: radius of each box, magnitude of the centre distance
    assign cabs_next = csum_reg[CSUM_W-1] ? CABS_W'(-csum_reg) : CABS_W'(csum_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= PSUM_W'(hp_reg[0]) + PSUM_W'(hp_reg[1]);
            pb_reg   <= PSUM_W'(hp_reg[2]) + PSUM_W'(hp_reg[3]);
            cabs_reg <= cabs_next;
        end
    end

    // stage 5: radius sum, distance scaled up by one axis unit
    always_ff @(posedge aclk) begin
        if (en) begin
            tot_reg <= TOT_W'(pa_reg) + TOT_W'(pb_reg);
            csh_reg <= {cabs_reg, {AXIS_FRAC{1'b0}}};
        end
    end

    // stage 6: strict compare, touching boxes do not separate
    always_ff @(posedge aclk) begin
        if (en) begin
            sep_reg <= CMP_W'(csh_reg) > CMP_W'(tot_reg);
        end
    end

    assign sep = sep_reg;

endmodule

// ----- sv/obb_obb_separating_axis_test_unit.sv -----
// Overlap test of two oriented boxes in the plane by separating axes.
// Input stream (s_): tuser is the request kind, load or test; tdata carries
// one box: centre x, y (signed Q16.16), half extents x, y (Q15.16) and two
// axes (signed Q1.14). A load request stores the box as the reference and
// gives no result. A test request gives one result on the output stream
// (m_): tdata bit 0 is set when no axis separates the boxes, touching
// counting as overlap.
// Pipeline: a test result passes six arithmetic stages (axis products,
// dot magnitudes and centre products, extent products, radii, radius sum,
// compare) and then the output register, the first stage loading on the
// edge that takes its request.
// Throughput: one request per cycle unless the receiver stalls; loads and
// tests alike are taken with s_tready high; each of four axes has a lane.
// A test sees every load taken before it, including one in the previous
// cycle.
// Reset clears the reference box to all zeros and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module obb_obb_separating_axis_test_unit
    import obbsat_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // center_x, center_y, half_x, half_y,
                                            // axis1_x, axis1_y, axis2_x, axis2_y
    input  logic                 s_tuser,  // req_type
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // overlap
);

    box_t                         in_box;
    box_t                         ref_box;
    logic                         en;
    logic                         s_take;
    logic                         load_en;
    logic                         test_en;

    logic [NSTAGE-1:0]            vld_reg, vld_next;
    logic signed [DIFF_W-1:0]     dx_reg, dy_reg;
    logic [NAXES-1:0][HALF_W-1:0] half1_reg, half2_reg;
    logic [NAXES-1:0]             sep;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_overlap_reg;

    logic signed [AXIS_WIDTH-1:0] lane_nx [NAXES];
    logic signed [AXIS_WIDTH-1:0] lane_ny [NAXES];

    // unpack the request
    assign in_box = box_t'(s_tdata[IN_BITS-1:0]);

    // the whole pipeline moves when the output register is free or drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign s_take   = s_tvalid && en;
    assign load_en  = s_take && (req_type_t'(s_tuser) == REQ_LOAD);
    assign test_en  = s_take && (req_type_t'(s_tuser) == REQ_TEST);

    obbsat_ref_store u_ref (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load_en (load_en),
        .box_in  (in_box),
        .ref_box (ref_box)
    );

    // stage 1 and 2 carriers: centre difference and the four half extents
    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= DIFF_W'(in_box.center_x) - DIFF_W'(ref_box.center_x);
            dy_reg    <= DIFF_W'(in_box.center_y) - DIFF_W'(ref_box.center_y);
            half1_reg <= {in_box.half_y, in_box.half_x, ref_box.half_y, ref_box.half_x};
            half2_reg <= half1_reg;
        end
    end

    // candidate axes: the reference's two, then the test box's two
    always_comb begin
        lane_nx[0] = ref_box.axes.a1x;  lane_ny[0] = ref_box.axes.a1y;
        lane_nx[1] = ref_box.axes.a2x;  lane_ny[1] = ref_box.axes.a2y;
        lane_nx[2] = in_box.axes.a1x;   lane_ny[2] = in_box.axes.a1y;
        lane_nx[3] = in_box.axes.a2x;   lane_ny[3] = in_box.axes.a2y;
    end

    for (genvar k = 0; k < NAXES; k++) begin : g_lane
        obbsat_axis_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .nx       (lane_nx[k]),
            .ny       (lane_ny[k]),
            .ref_axes (ref_box.axes),
            .tst_axes (in_box.axes),
            .dx       (dx_reg),
            .dy       (dy_reg),
            .half     (half2_reg),
            .sep      (sep[k])
        );
    end

    // valid bits of test requests travel beside the lane stages
    always_comb begin
        vld_next      = vld_reg;
        m_tvalid_next = m_tvalid_reg;
        if (en) begin
            vld_next      = {vld_reg[NSTAGE-2:0], test_en};
            m_tvalid_next = vld_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register: overlap unless some axis separates
    always_ff @(posedge aclk) begin
        if (en) begin
            m_overlap_reg <= ~|sep;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_overlap_reg);

`ifndef SYNTHESIS
    // a load request never enters the result pipeline
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser) |=> !vld_reg[0])
        else $error("load request entered the result pipeline");

    // a test request always enters the result pipeline
    a_test_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> vld_reg[0])
        else $error("test request lost at entry");

    // a stall freezes every valid bit of the pipeline
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> ($stable(vld_reg) && m_tvalid))
        else $error("pipeline moved during a stall");

    // the last stage only hands on when the output side can take it
    a_drain_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTAGE-1] && s_tready) |=> m_tvalid)
        else $error("result dropped at the output register");
`endif

endmodule
